FILE: rtl/wksd_pkg.sv
package wksd_pkg;

   // sample store geometry
   localparam int SAMPLE_AW   = 10;
   localparam int MAX_SAMPLES = 1 << SAMPLE_AW;
   localparam int CNT_W       = SAMPLE_AW + 1;

   // field widths
   localparam int VAL_W = 32;
   localparam int WGT_W = 32;
   localparam int ENT_W = VAL_W + WGT_W;

   // running sums hold up to MAX_SAMPLES full-scale weights
   localparam int SUM_W = WGT_W + SAMPLE_AW;

   localparam logic [WGT_W-1:0] ONE_Q31 = WGT_W'(64'h8000_0000);

   // configuration register indexes
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_REF_COUNT  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_TEST_COUNT = CSR_IDX_W'(1);

   // controller to datapath
   typedef struct packed {
      logic                 wr_en;
      logic                 wr_test;
      logic [SAMPLE_AW-1:0] wr_addr;
      logic [SAMPLE_AW-1:0] rd_ref_addr;
      logic [SAMPLE_AW-1:0] rd_test_addr;
      logic                 lead_is_ref;
      logic                 init;
      logic                 take_other;
      logic                 take_lead;
      logic                 upd_best;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic ref_first_lt;
      logic other_lt_lead;
   } dp_stat_type;

   // clamp a configured count into 1..MAX_SAMPLES
   function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] c);
      logic [CNT_W-1:0] r;
      begin
         if (c == '0) begin
            r = CNT_W'(1);
         end else if (c > CNT_W'(MAX_SAMPLES)) begin
            r = CNT_W'(MAX_SAMPLES);
         end else begin
            r = c;
         end
         return r;
      end
   endfunction

endpackage

FILE: rtl/wksd_dpath.sv
module wksd_dpath (
   input  logic                              clock,
   input  wksd_pkg::dp_cmd_type              cmd,
   input  logic signed [wksd_pkg::VAL_W-1:0] wr_value,
   input  logic [wksd_pkg::WGT_W-1:0]        wr_weight,
   output wksd_pkg::dp_stat_type             stat,
   output logic [wksd_pkg::WGT_W-1:0]        distance
);
   import wksd_pkg::*;

   logic [ENT_W-1:0] ref_mem  [MAX_SAMPLES];
   logic [ENT_W-1:0] test_mem [MAX_SAMPLES];
   logic [ENT_W-1:0] ref_rd_ff;
   logic [ENT_W-1:0] test_rd_ff;

   logic signed [VAL_W-1:0] ref_val, test_val, lead_val, other_val;
   logic [WGT_W-1:0]        ref_wgt, test_wgt, lead_wgt, other_wgt, first_wgt;

   logic [SUM_W-1:0] sum_lead_ff, sum_lead_in;
   logic [SUM_W-1:0] sum_other_ff, sum_other_in;
   logic [SUM_W-1:0] best_ff, best_in;
   logic [SUM_W:0]   d_lo, d_ol;
   logic [SUM_W-1:0] diff;

   // reference store: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (cmd.wr_en && !cmd.wr_test) begin
         ref_mem[cmd.wr_addr] <= {wr_value, wr_weight};
      end
      ref_rd_ff <= ref_mem[cmd.rd_ref_addr];
   end

   // compared store
   always_ff @(posedge clock) begin
      if (cmd.wr_en && cmd.wr_test) begin
         test_mem[cmd.wr_addr] <= {wr_value, wr_weight};
      end
      test_rd_ff <= test_mem[cmd.rd_test_addr];
   end

   // split entries and route them to lead and other
   always_comb begin
      ref_val   = signed'(ref_rd_ff[ENT_W-1:WGT_W]);
      test_val  = signed'(test_rd_ff[ENT_W-1:WGT_W]);
      ref_wgt   = ref_rd_ff[WGT_W-1:0];
      test_wgt  = test_rd_ff[WGT_W-1:0];
      lead_val  = cmd.lead_is_ref ? ref_val : test_val;
      other_val = cmd.lead_is_ref ? test_val : ref_val;
      lead_wgt  = cmd.lead_is_ref ? ref_wgt : test_wgt;
      other_wgt = cmd.lead_is_ref ? test_wgt : ref_wgt;
      stat.ref_first_lt  = ref_val < test_val;
      stat.other_lt_lead = other_val < lead_val;
      first_wgt = stat.ref_first_lt ? ref_wgt : test_wgt;
   end

   // absolute difference of the running sums
   always_comb begin
      d_lo = {1'b0, sum_lead_ff} - {1'b0, sum_other_ff};
      d_ol = {1'b0, sum_other_ff} - {1'b0, sum_lead_ff};
      diff = d_lo[SUM_W] ? d_ol[SUM_W-1:0] : d_lo[SUM_W-1:0];
   end

   // accumulate weights and track the largest gap
   always_comb begin
      sum_lead_in  = sum_lead_ff;
      sum_other_in = sum_other_ff;
      best_in      = best_ff;
      if (cmd.init) begin
         sum_lead_in  = SUM_W'(first_wgt);
         sum_other_in = '0;
         best_in      = SUM_W'(first_wgt);
      end
      if (cmd.take_other) begin
         sum_other_in = sum_other_ff + SUM_W'(other_wgt);
      end
      if (cmd.take_lead) begin
         sum_lead_in = sum_lead_ff + SUM_W'(lead_wgt);
      end
      if (cmd.upd_best && (diff > best_ff)) begin
         best_in = diff;
      end
   end

   always_ff @(posedge clock) begin
      sum_lead_ff  <= sum_lead_in;
      sum_other_ff <= sum_other_in;
      best_ff      <= best_in;
   end

   // saturate at 1.0
   assign distance = (best_ff > SUM_W'(ONE_Q31)) ? ONE_Q31 : best_ff[WGT_W-1:0];

endmodule

FILE: rtl/wksd_ctrl.sv
module wksd_ctrl (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic                              set_select,
   output logic                              busy,
   output logic                              rsp_valid,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [wksd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [wksd_pkg::CNT_W-1:0]        csr_data,
   output wksd_pkg::dp_cmd_type              cmd,
   input  wksd_pkg::dp_stat_type             stat
);
   import wksd_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIRST_RD,
      ST_FIRST_CMP,
      ST_ISSUE,
      ST_EVAL,
      ST_FINISH
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] ref_count_ff, ref_count_in;
   logic [CNT_W-1:0] test_count_ff, test_count_in;
   logic [CNT_W-1:0] ref_fill_ff, ref_fill_in;
   logic [CNT_W-1:0] test_fill_ff, test_fill_in;
   logic [CNT_W-1:0] i_ff, i_in;
   logic [CNT_W-1:0] j_ff, j_in;
   logic [CNT_W-1:0] nlead_ff, nlead_in;
   logic [CNT_W-1:0] nother_ff, nother_in;
   logic             lead_is_ref_ff, lead_is_ref_in;

   logic [CNT_W-1:0] nref, ntest, ref_fill_nx, test_fill_nx;
   logic             accept, ref_take, test_take, round_done;

   assign csr_ready = 1'b1;
   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_FINISH);

   // load bookkeeping
   always_comb begin
      nref         = eff_count(ref_count_ff);
      ntest        = eff_count(test_count_ff);
      accept       = start && !busy;
      ref_take     = accept && !set_select && (ref_fill_ff < nref);
      test_take    = accept && set_select && (test_fill_ff < ntest);
      ref_fill_nx  = ref_fill_ff + CNT_W'(ref_take);
      test_fill_nx = test_fill_ff + CNT_W'(test_take);
      round_done   = accept && (ref_fill_nx >= nref) && (test_fill_nx >= ntest);
   end

   // next state and datapath commands
   always_comb begin
      state_in       = state_ff;
      ref_count_in   = ref_count_ff;
      test_count_in  = test_count_ff;
      ref_fill_in    = ref_fill_nx;
      test_fill_in   = test_fill_nx;
      i_in           = i_ff;
      j_in           = j_ff;
      nlead_in       = nlead_ff;
      nother_in      = nother_ff;
      lead_is_ref_in = lead_is_ref_ff;

      cmd.wr_en        = ref_take || test_take;
      cmd.wr_test      = set_select;
      cmd.wr_addr      = set_select ? test_fill_ff[SAMPLE_AW-1:0]
                                    : ref_fill_ff[SAMPLE_AW-1:0];
      cmd.rd_ref_addr  = lead_is_ref_ff ? i_ff[SAMPLE_AW-1:0] : j_ff[SAMPLE_AW-1:0];
      cmd.rd_test_addr = lead_is_ref_ff ? j_ff[SAMPLE_AW-1:0] : i_ff[SAMPLE_AW-1:0];
      cmd.lead_is_ref  = lead_is_ref_ff;
      cmd.init         = 1'b0;
      cmd.take_other   = 1'b0;
      cmd.take_lead    = 1'b0;
      cmd.upd_best     = 1'b0;

      // register writes
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_REF_COUNT:  ref_count_in  = csr_data;
            CSR_TEST_COUNT: test_count_in = csr_data;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (round_done) begin
               ref_fill_in  = '0;
               test_fill_in = '0;
               state_in     = ST_FIRST_RD;
            end
         end
         ST_FIRST_RD: begin
            // fetch the first entry of both sets
            cmd.rd_ref_addr  = '0;
            cmd.rd_test_addr = '0;
            state_in         = ST_FIRST_CMP;
         end
         ST_FIRST_CMP: begin
            // pick the lead: compared set wins a tie
            cmd.init       = 1'b1;
            lead_is_ref_in = stat.ref_first_lt;
            nlead_in       = stat.ref_first_lt ? nref : ntest;
            nother_in      = stat.ref_first_lt ? ntest : nref;
            i_in           = CNT_W'(1);
            j_in           = '0;
            state_in       = ST_ISSUE;
         end
         ST_ISSUE: begin
            // fold the last step into the maximum, then fetch the next pair
            cmd.upd_best = 1'b1;
            state_in     = (i_ff >= nlead_ff) ? ST_FINISH : ST_EVAL;
         end
         ST_EVAL: begin
            // advance the other set only on a strictly smaller value
            if ((j_ff < nother_ff) && stat.other_lt_lead) begin
               cmd.take_other = 1'b1;
               j_in           = j_ff + CNT_W'(1);
            end else begin
               cmd.take_lead = 1'b1;
               i_in          = i_ff + CNT_W'(1);
            end
            state_in = ST_ISSUE;
         end
         ST_FINISH: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         ref_count_ff   <= CNT_W'(MAX_SAMPLES);
         test_count_ff  <= CNT_W'(MAX_SAMPLES);
         ref_fill_ff    <= '0;
         test_fill_ff   <= '0;
         i_ff           <= '0;
         j_ff           <= '0;
         nlead_ff       <= CNT_W'(1);
         nother_ff      <= CNT_W'(1);
         lead_is_ref_ff <= 1'b0;
      end else begin
         state_ff       <= state_in;
         ref_count_ff   <= ref_count_in;
         test_count_ff  <= test_count_in;
         ref_fill_ff    <= ref_fill_in;
         test_fill_ff   <= test_fill_in;
         i_ff           <= i_in;
         j_ff           <= j_in;
         nlead_ff       <= nlead_in;
         nother_ff      <= nother_in;
         lead_is_ref_ff <= lead_is_ref_in;
      end
   end

   a_rsp_then_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy)
      else $error("result strobe not followed by idle");

   a_lead_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EVAL) |-> (i_ff < nlead_ff))
      else $error("lead index past its count during walk");

   a_other_in_range: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_ISSUE) || (state_ff == ST_EVAL)) |-> (j_ff <= nother_ff))
      else $error("other index past its count during walk");

   a_round_clears: assert property (@(posedge clock) disable iff (reset)
      round_done |=> (busy && (ref_fill_ff == '0) && (test_fill_ff == '0)))
      else $error("completed round did not clear fills and start walk");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      (ref_fill_ff <= CNT_W'(MAX_SAMPLES)) && (test_fill_ff <= CNT_W'(MAX_SAMPLES)))
      else $error("fill count beyond store depth");

endmodule

FILE: rtl/weighted_ks_distance_unit.sv
// Loading: a request is taken whenever busy is low; busy stays low unless it completes both sets.
// Completing request: both first entries are read and compared to pick the lead; the walk then
// covers the lead set's nlead entries and the k other-set entries visited; each merge step is
// a registered store read, then accumulate. busy is high until the rsp_valid strobe ends.
// Reset (synchronous, high) clears fills and sets both counts to 1024; stores are not cleared.
// The receiver cannot stall: the result is valid for exactly one cycle.
module weighted_ks_distance_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_set_select,
   input  logic signed [wksd_pkg::VAL_W-1:0] req_sample_value,
   input  logic [wksd_pkg::WGT_W-1:0]        req_sample_weight,
   output logic                              rsp_valid,
   output logic [wksd_pkg::WGT_W-1:0]        rsp_ks_distance,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [wksd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [wksd_pkg::CNT_W-1:0]        csr_data
);
   import wksd_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   // sequencing, counts and fills
   wksd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .set_select (req_set_select),
      .busy       (busy),
      .rsp_valid  (rsp_valid),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .cmd        (cmd),
      .stat       (stat)
   );

   // sample stores, running sums and maximum
   wksd_dpath u_dpath (
      .clock     (clock),
      .cmd       (cmd),
      .wr_value  (req_sample_value),
      .wr_weight (req_sample_weight),
      .stat      (stat),
      .distance  (rsp_ks_distance)
   );

endmodule

FILE: tb/sv/tb_weighted_ks_distance_unit.sv
module tb_weighted_ks_distance_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import wksd_pkg::*;

   // one stored sample: position and weight
   typedef struct packed {
      logic signed [VAL_W-1:0] pos;
      logic [WGT_W-1:0]        wgt;
   } sample_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    start = 1'b0;
   logic                    busy;
   logic                    req_set_select = 1'b0;
   logic signed [VAL_W-1:0] req_sample_value = '0;
   logic [WGT_W-1:0]        req_sample_weight = '0;
   logic                    rsp_valid;
   logic [WGT_W-1:0]        rsp_ks_distance;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CSR_IDX_W-1:0]    csr_index = CSR_REF_COUNT;
   logic [CNT_W-1:0]        csr_data = '0;

   // predictor state: sample stores, fill levels and programmed counts
   sample_type       ref_mem [MAX_SAMPLES];
   sample_type       test_mem [MAX_SAMPLES];
   int unsigned      ref_fill = 0;
   int unsigned      test_fill = 0;
   logic [CNT_W-1:0] ref_count_q = CNT_W'(1024);
   logic [CNT_W-1:0] test_count_q = CNT_W'(1024);

   // distances still owed by the block, oldest first
   logic [WGT_W-1:0] dist_q [$];
   logic [WGT_W-1:0] expected_dist;

   // positions prepared for the round being sent, per set
   int               round_pos [2][MAX_SAMPLES];

   int unsigned      sender_idle_pct = 0;
   int unsigned      loaded_items = 0;
   int unsigned      ignored_items = 0;
   int unsigned      rounds_done = 0;
   int unsigned      error_count = 0;

   weighted_ks_distance_unit dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_set_select    (req_set_select),
      .req_sample_value  (req_sample_value),
      .req_sample_weight (req_sample_weight),
      .rsp_valid         (rsp_valid),
      .rsp_ks_distance   (rsp_ks_distance),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // clamp a programmed count into 1..MAX_SAMPLES
   function automatic int unsigned clamp_count(input logic [CNT_W-1:0] c);
      if (c == '0) return 1;
      if (c > CNT_W'(MAX_SAMPLES)) return MAX_SAMPLES;
      return int'(c);
   endfunction

   function automatic sample_type stored(input bit from_test, input int unsigned idx);
      return from_test ? test_mem[idx] : ref_mem[idx];
   endfunction

   // merge-walk both stores and return the saturated largest cumulative gap
   function automatic logic [WGT_W-1:0] ks_of_round(input int unsigned nref,
                                                   input int unsigned ntest);
      bit          lead_test;
      bit          walking;
      int unsigned nlead, nother, i, j;
      longint      sum_lead, sum_other, best, d;
      sample_type  lead_s, other_s;
      // the compared set leads unless the reference starts strictly lower
      lead_test = !($signed(ref_mem[0].pos) < $signed(test_mem[0].pos));
      nlead = lead_test ? ntest : nref;
      nother = lead_test ? nref : ntest;
      lead_s = stored(lead_test, 0);
      sum_lead = longint'({32'd0, lead_s.wgt});
      sum_other = 0;
      best = sum_lead;
      j = 0;
      for (i = 1; i < nlead; i++) begin
         lead_s = stored(lead_test, i);
         walking = 1'b1;
         // take other-set entries that sit strictly below this lead entry
         while (walking && j < nother) begin
            other_s = stored(!lead_test, j);
            if ($signed(other_s.pos) < $signed(lead_s.pos)) begin
               sum_other += longint'({32'd0, other_s.wgt});
               d = (sum_other > sum_lead) ? sum_other - sum_lead : sum_lead - sum_other;
               if (d > best) best = d;
               j++;
            end else begin
               walking = 1'b0;
            end
         end
         sum_lead += longint'({32'd0, lead_s.wgt});
         d = (sum_other > sum_lead) ? sum_other - sum_lead : sum_lead - sum_other;
         if (d > best) best = d;
      end
      if (best > longint'({32'd0, ONE_Q31})) best = longint'({32'd0, ONE_Q31});
      return best[WGT_W-1:0];
   endfunction

   // drive one request, hold it until taken, then advance the predictor
   task automatic send_sample(input bit to_test, input logic signed [VAL_W-1:0] pos,
                              input logic [WGT_W-1:0] wgt);
      int unsigned nref, ntest;
      if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      start <= 1'b1;
      req_set_select <= to_test;
      req_sample_value <= pos;
      req_sample_weight <= wgt;
      do @(posedge clock); while (busy);
      nref = clamp_count(ref_count_q);
      ntest = clamp_count(test_count_q);
      if (!to_test && ref_fill < nref) begin
         ref_mem[ref_fill].pos = pos;
         ref_mem[ref_fill].wgt = wgt;
         ref_fill++;
         loaded_items++;
      end else if (to_test && test_fill < ntest) begin
         test_mem[test_fill].pos = pos;
         test_mem[test_fill].wgt = wgt;
         test_fill++;
         loaded_items++;
      end else begin
         ignored_items++;
      end
      // both sets complete: the block owes one distance and starts a new round
      if (ref_fill >= nref && test_fill >= ntest) begin
         dist_q.push_back(ks_of_round(nref, ntest));
         ref_fill = 0;
         test_fill = 0;
         rounds_done++;
      end
   endtask

   // drop start and wait out every owed distance plus the loading latency
   task automatic drain_results();
      start <= 1'b0;
      while (dist_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // program both counts once the block is quiet
   task automatic reconfigure(input logic [CNT_W-1:0] ref_cnt, input logic [CNT_W-1:0] test_cnt);
      drain_results();
      csr_valid <= 1'b1;
      csr_index <= CSR_REF_COUNT;
      csr_data <= ref_cnt;
      do @(posedge clock); while (!csr_ready);
      ref_count_q = ref_cnt;
      csr_index <= CSR_TEST_COUNT;
      csr_data <= test_cnt;
      do @(posedge clock); while (!csr_ready);
      test_count_q = test_cnt;
      csr_valid <= 1'b0;
   endtask

   // check each strobed distance against the oldest owed one
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (dist_q.size() == 0) begin
            $display("%0t: unexpected distance %h with none owed", $time, rsp_ks_distance);
            error_count++;
         end else begin
            expected_dist = dist_q.pop_front();
            if (rsp_ks_distance !== expected_dist) begin
               $display("%0t: ks_distance expected %h actual %h", $time, expected_dist,
                        rsp_ks_distance);
               error_count++;
            end
         end
      end
   end

   function automatic logic [WGT_W-1:0] random_weight();
      case ($urandom_range(9))
         0, 1, 2, 3: return $urandom_range(0, 32'h8000_0000);
         4, 5:       return $urandom_range(0, 32'h0800_0000);
         6, 9:       return $urandom;
         7:          return '0;
         default:    return ONE_Q31;
      endcase
   endfunction

   function automatic logic [CNT_W-1:0] random_count();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 5) return '0;
      if (r < 80) return CNT_W'($urandom_range(1, 6));
      if (r < 96) return CNT_W'($urandom_range(7, 40));
      return CNT_W'($urandom_range(41, 100));
   endfunction

   // fill one set's positions: wide sorted, narrow sorted (many ties) or unsorted
   function automatic void make_positions(input bit set_idx, input int unsigned n,
                                          input int unsigned shape, input int base);
      int unsigned i, k;
      int          key;
      for (i = 0; i < n; i++) begin
         if (shape == 1) round_pos[set_idx][i] = base + int'($urandom_range(0, 3 * n));
         else round_pos[set_idx][i] = int'($urandom);
      end
      if (shape != 2) begin
         for (i = 1; i < n; i++) begin
            key = round_pos[set_idx][i];
            k = i;
            while (k > 0 && round_pos[set_idx][k-1] > key) begin
               round_pos[set_idx][k] = round_pos[set_idx][k-1];
               k--;
            end
            round_pos[set_idx][k] = key;
         end
      end
   endfunction

   // send one round interleaved; sometimes add requests to a full set or break off early
   task automatic run_random_round(input int unsigned shape);
      int unsigned nref, ntest, ri, ti, sent, cut;
      int          base, lowest;
      bit          to_test;
      nref = clamp_count(ref_count_q);
      ntest = clamp_count(test_count_q);
      base = int'($urandom);
      make_positions(1'b0, nref, shape, base);
      make_positions(1'b1, ntest, shape, base);
      // force equal first positions now and then
      if (shape != 2 && $urandom_range(5) == 0) begin
         lowest = (round_pos[0][0] < round_pos[1][0]) ? round_pos[0][0] : round_pos[1][0];
         round_pos[0][0] = lowest;
         round_pos[1][0] = lowest;
      end
      ri = ref_fill;
      ti = test_fill;
      sent = 0;
      cut = ($urandom_range(19) == 0) ? $urandom_range(1, nref + ntest) : 0;
      while ((ri < nref || ti < ntest) && (cut == 0 || sent < cut)) begin
         if ((ri >= nref || ti >= ntest) && $urandom_range(7) == 0) begin
            send_sample(ti >= ntest, $urandom, random_weight());
         end else begin
            if (ri >= nref) to_test = 1'b1;
            else if (ti >= ntest) to_test = 1'b0;
            else to_test = 1'($urandom_range(1));
            if (to_test) begin
               send_sample(1'b1, round_pos[1][ti], random_weight());
               ti++;
            end else begin
               send_sample(1'b0, round_pos[0][ri], random_weight());
               ri++;
            end
         end
         sent++;
      end
   endtask

   // field extremes, lead on a tie, equal positions across sets, saturation
   task automatic test_directed_corners();
      sender_idle_pct = 0;
      reconfigure(CNT_W'(1), CNT_W'(1));
      send_sample(1'b0, 32'sd100, 32'h4000_0000);
      send_sample(1'b1, 32'sd100, 32'h1000_0000);
      send_sample(1'b1, 32'sh8000_0000, 32'h0000_0000);
      send_sample(1'b0, 32'sh7FFF_FFFF, 32'hFFFF_FFFF);
      reconfigure(CNT_W'(2), CNT_W'(3));
      send_sample(1'b0, 32'sh8000_0000, 32'h0000_0000);
      send_sample(1'b1, -32'sd5, 32'h8000_0000);
      send_sample(1'b1, -32'sd5, 32'h1234_5678);
      send_sample(1'b0, 32'sh7FFF_FFFF, 32'hFFFF_FFFF);
      send_sample(1'b0, 32'sd0, 32'hFFFF_FFFF);
      send_sample(1'b1, 32'sd7, 32'hFFFF_FFFF);
      reconfigure(CNT_W'(3), CNT_W'(3));
      send_sample(1'b0, 32'sd0, 32'h1000_0000);
      send_sample(1'b1, 32'sd10, 32'h3000_0000);
      send_sample(1'b0, 32'sd10, 32'h2000_0000);
      send_sample(1'b1, 32'sd20, 32'h0400_0000);
      send_sample(1'b0, 32'sd20, 32'h0800_0000);
      send_sample(1'b1, 32'sd30, 32'h7000_0000);
   endtask

   // lower counts below the fill of a round in progress
   task automatic test_lowered_counts();
      sender_idle_pct = 0;
      reconfigure(CNT_W'(4), CNT_W'(2));
      send_sample(1'b0, -32'sd300, 32'h0100_0000);
      send_sample(1'b0, -32'sd200, 32'h0200_0000);
      send_sample(1'b0, -32'sd100, 32'h0300_0000);
      send_sample(1'b1, -32'sd250, 32'h0400_0000);
      reconfigure(CNT_W'(2), CNT_W'(2));
      send_sample(1'b0, 32'sd50, 32'h7FFF_FFFF);
      send_sample(1'b1, -32'sd150, 32'h0500_0000);
      // completion on an ignored request, with a zero count acting as one
      reconfigure(CNT_W'(3), CNT_W'(3));
      send_sample(1'b0, 32'sd1, 32'h2000_0000);
      send_sample(1'b1, 32'sd2, 32'h3000_0000);
      send_sample(1'b0, 32'sd3, 32'h4000_0000);
      reconfigure(CNT_W'(0), CNT_W'(1));
      send_sample(1'b0, 32'sd4, 32'h5000_0000);
   endtask

   // a count above the store depth acts as the full depth and holds the round open
   task automatic test_count_clamp();
      sender_idle_pct = 0;
      reconfigure(CNT_W'(2047), CNT_W'(0));
      send_sample(1'b0, -32'sd40, 32'h0100_0000);
      send_sample(1'b0, -32'sd20, 32'h0200_0000);
      send_sample(1'b1, -32'sd30, 32'h0300_0000);
      send_sample(1'b0, 32'sd0, 32'h0400_0000);
      send_sample(1'b1, 32'sd10, 32'h0500_0000);
      // shrink the reference count to what is held; the next request completes
      reconfigure(CNT_W'(3), CNT_W'(1));
      send_sample(1'b1, 32'sd50, 32'h0600_0000);
   endtask

   // random rounds through the sender idle phases
   task automatic test_random_rounds();
      int unsigned idle_plan [4];
      int unsigned p, phase_start, shape;
      idle_plan = '{0, 47, 32, 0};
      for (p = 0; p < 4; p++) begin
         sender_idle_pct = idle_plan[p];
         phase_start = loaded_items;
         while (loaded_items - phase_start < 140) begin
            reconfigure(random_count(), random_count());
            repeat ($urandom_range(1, 4)) begin
               shape = $urandom_range(9);
               run_random_round(shape < 6 ? 0 : (shape < 9 ? 1 : 2));
               if ($urandom_range(7) == 0) drain_results();
            end
         end
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_directed_corners();
      test_lowered_counts();
      test_count_clamp();
      test_random_rounds();
      drain_results();
      $display("Covered %0d rounds from %0d loaded and %0d ignored requests,", rounds_done,
               loaded_items, ignored_items);
      $display("counts 0 to 2047, tied and unsorted positions, sender idle 0/47/32 pct");
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // hard stop well beyond the slowest legal run
   initial begin
      #5_000_000;
      $display("Timed out with %0d distances still owed", dist_q.size());
      $display("Simulation FAILED");
      $finish;
   end

endmodule
